@@ hdl/mbq_pkg.sv @@
// shared types and constants for the memory bank queue timing model
// no dependencies; used by every module of the block by scoped names
package mbq_pkg;

  // waiting queue geometry
  localparam int QUEUE_DEPTH = 16;
  localparam int PTR_W       = $clog2(QUEUE_DEPTH);
  localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

  // field widths
  localparam int ID_W       = 16;
  localparam int SIZE_W     = 16;
  localparam int CFG_W      = 16;
  localparam int BG_W       = 8;
  localparam int LAT_W      = 32;
  localparam int QLEN_W     = 5;
  localparam int CFG_IDX_W  = 2;
  localparam int IN_DATA_W  = ID_W + SIZE_W;
  localparam int OUT_DATA_W = 1 + ID_W + 1 + QLEN_W + 1;
  localparam int ENTRY_W    = ID_W + SIZE_W;

  // divider geometry
  localparam int DIV_N_W   = 32;
  localparam int DIV_D_W   = 16;
  localparam int DIV_CNT_W = $clog2(DIV_N_W);

  // register reset values
  localparam logic [CFG_W-1:0] NOMINAL_RST = 16'd16;
  localparam logic [CFG_W-1:0] COEFF_RST   = 16'd100;
  localparam logic [BG_W-1:0]  BG_RST      = 8'd0;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_NOMINAL    = 2'd0,
    REG_COEFF      = 2'd1,
    REG_BACKGROUND = 2'd2
  } cfg_reg_t;

  // operation codes
  localparam logic OP_ARRIVE = 1'b0;
  localparam logic OP_TICK   = 1'b1;

  // controller states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_FETCH,
    ST_MUL,
    ST_DIV1,
    ST_DIV2,
    ST_RESULT
  } state_t;

  // commands from controller to datapath
  typedef struct packed {
    logic latch_item;
    logic start_new;
    logic enqueue;
    logic set_ovf;
    logic dec_rem;
    logic finish;
    logic pop;
    logic load_fetch;
    logic mul_start;
    logic div2_start;
    logic set_latency;
    logic load_out;
  } cmd_t;

  // status from datapath to controller
  typedef struct packed {
    logic op;
    logic serving;
    logic rem_le1;
    logic nonempty;
    logic full;
    logic div_done;
    logic out_busy;
  } status_t;

endpackage

@@ hdl/mbq_div.sv @@
// iterative restoring divider, one quotient bit per cycle
// depends on mbq_pkg for widths
module mbq_div (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [mbq_pkg::DIV_N_W-1:0] dividend,
  input  logic [mbq_pkg::DIV_D_W-1:0] divisor,
  output logic                        busy,
  output logic                        done,
  output logic [mbq_pkg::DIV_N_W-1:0] quotient
);

  logic [mbq_pkg::DIV_D_W-1:0]   part_rem;
  logic [mbq_pkg::DIV_D_W-1:0]   dvs;
  logic [mbq_pkg::DIV_N_W-1:0]   shreg;
  logic [mbq_pkg::DIV_CNT_W-1:0] cnt;
  logic [mbq_pkg::DIV_D_W:0]     rem_shift;
  logic [mbq_pkg::DIV_D_W:0]     diff;
  logic                          ge;

  // one trial subtraction per cycle
  always_comb begin
    rem_shift = {part_rem, shreg[mbq_pkg::DIV_N_W-1]};
    ge        = rem_shift >= {1'b0, dvs};
    diff      = rem_shift - {1'b0, dvs};
  end

  // control of the iteration
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + mbq_pkg::DIV_CNT_W'(1);
        if (cnt == mbq_pkg::DIV_CNT_W'(mbq_pkg::DIV_N_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // partial remainder and quotient shift register
  always_ff @(posedge clk) begin
    if (start) begin
      part_rem <= '0;
      dvs      <= divisor;
      shreg    <= dividend;
    end else if (busy) begin
      part_rem <= ge ? diff[mbq_pkg::DIV_D_W-1:0] : rem_shift[mbq_pkg::DIV_D_W-1:0];
      shreg    <= {shreg[mbq_pkg::DIV_N_W-2:0], ge};
    end
  end

  assign quotient = shreg;

`ifndef ASSERT_OFF
  a_start_idle: assert property (@(posedge clk) disable iff (rst) start |-> !busy)
    else $error("divider started while busy");
  a_done_idle: assert property (@(posedge clk) disable iff (rst) done |-> !busy)
    else $error("divider done while still iterating");
`endif

endmodule

@@ hdl/mbq_ctrl.sv @@
// controller state machine: sequences one item through the datapath
// depends on mbq_pkg for state, command and status types
module mbq_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             s_tvalid,
  output logic             s_tready,
  input  mbq_pkg::status_t stat,
  output mbq_pkg::cmd_t    cmd
);

  mbq_pkg::state_t state, state_next;
  logic            arrival;

  assign arrival = stat.op == mbq_pkg::OP_ARRIVE;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= mbq_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      mbq_pkg::ST_IDLE: begin
        if (s_tvalid) state_next = mbq_pkg::ST_EXEC;
      end
      mbq_pkg::ST_EXEC: begin
        if (arrival && !stat.serving) begin
          state_next = mbq_pkg::ST_MUL;
        end else if (!arrival && stat.serving && stat.rem_le1 && stat.nonempty) begin
          state_next = mbq_pkg::ST_FETCH;
        end else begin
          state_next = mbq_pkg::ST_RESULT;
        end
      end
      mbq_pkg::ST_FETCH: state_next = mbq_pkg::ST_MUL;
      mbq_pkg::ST_MUL:   state_next = mbq_pkg::ST_DIV1;
      mbq_pkg::ST_DIV1: begin
        if (stat.div_done) state_next = mbq_pkg::ST_DIV2;
      end
      mbq_pkg::ST_DIV2: begin
        if (stat.div_done) state_next = mbq_pkg::ST_RESULT;
      end
      mbq_pkg::ST_RESULT: begin
        if (!stat.out_busy) state_next = mbq_pkg::ST_IDLE;
      end
      default: state_next = mbq_pkg::ST_IDLE;
    endcase
  end

  // command outputs
  always_comb begin
    cmd      = '0;
    s_tready = 1'b0;
    unique case (state)
      mbq_pkg::ST_IDLE: begin
        s_tready       = 1'b1;
        cmd.latch_item = s_tvalid;
      end
      mbq_pkg::ST_EXEC: begin
        cmd.start_new = arrival && !stat.serving;
        cmd.enqueue   = arrival && stat.serving && !stat.full;
        cmd.set_ovf   = arrival && stat.serving && stat.full;
        cmd.dec_rem   = !arrival && stat.serving && !stat.rem_le1;
        cmd.finish    = !arrival && stat.serving && stat.rem_le1;
        cmd.pop       = !arrival && stat.serving && stat.rem_le1 && stat.nonempty;
      end
      mbq_pkg::ST_FETCH:  cmd.load_fetch  = 1'b1;
      mbq_pkg::ST_MUL:    cmd.mul_start   = 1'b1;
      mbq_pkg::ST_DIV1:   cmd.div2_start  = stat.div_done;
      mbq_pkg::ST_DIV2:   cmd.set_latency = stat.div_done;
      mbq_pkg::ST_RESULT: cmd.load_out    = !stat.out_busy;
      default: cmd = '0;
    endcase
  end

endmodule

@@ hdl/mbq_datapath.sv @@
// datapath: configuration registers, bank state, waiting queue memory,
// multiplier, shared divider and output register; depends on mbq_pkg, mbq_div
module mbq_datapath (
  input  logic                           clk,
  input  logic                           rst,
  // configuration writes
  input  logic                           cfg_valid,
  input  logic [mbq_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [mbq_pkg::CFG_W-1:0]      cfg_data,
  // input item payload
  input  logic                           s_tuser,
  input  logic [mbq_pkg::IN_DATA_W-1:0]  s_tdata,
  // result channel
  input  logic                           m_tready,
  output logic                           m_tvalid,
  output logic [mbq_pkg::OUT_DATA_W-1:0] m_tdata,
  // controller link
  input  mbq_pkg::cmd_t                  cmd,
  output mbq_pkg::status_t               stat
);

  // configuration
  logic [mbq_pkg::CFG_W-1:0] nominal_bw;
  logic [mbq_pkg::CFG_W-1:0] coeff;
  logic [mbq_pkg::BG_W-1:0]  background;

  // latched item
  logic                       item_op;
  logic [mbq_pkg::ID_W-1:0]   item_id;
  logic [mbq_pkg::SIZE_W-1:0] item_size;

  // bank state
  logic                       serving;
  logic [mbq_pkg::LAT_W-1:0]  remaining;
  logic [mbq_pkg::ID_W-1:0]   current_id;
  logic [mbq_pkg::SIZE_W-1:0] svc_size;
  logic [mbq_pkg::CNT_W-1:0]  count;
  logic [mbq_pkg::PTR_W-1:0]  head;
  logic                       done_flag;
  logic [mbq_pkg::ID_W-1:0]   done_id;
  logic                       ovf_flag;

  // waiting queue
  logic [mbq_pkg::ENTRY_W-1:0] queue_mem [mbq_pkg::QUEUE_DEPTH];
  logic [mbq_pkg::ENTRY_W-1:0] rd_entry;
  logic [mbq_pkg::PTR_W:0]     tail_sum;
  logic [mbq_pkg::PTR_W-1:0]   tail;
  logic [mbq_pkg::PTR_W-1:0]   head_next;
  logic                        full;

  // latency arithmetic
  logic [mbq_pkg::DIV_N_W-1:0] product;
  logic [mbq_pkg::DIV_D_W-1:0] total;
  logic [mbq_pkg::DIV_D_W-1:0] bw_fixed;
  logic [mbq_pkg::DIV_N_W-1:0] div_q;
  logic                        div_start;
  logic                        div_busy;
  logic                        div_done;
  logic [mbq_pkg::DIV_N_W-1:0] div_dividend;
  logic [mbq_pkg::DIV_D_W-1:0] div_divisor;

  // configuration register writes, unknown index ignored
  always_ff @(posedge clk) begin
    if (rst) begin
      nominal_bw <= mbq_pkg::NOMINAL_RST;
      coeff      <= mbq_pkg::COEFF_RST;
      background <= mbq_pkg::BG_RST;
    end else if (cfg_valid) begin
      unique case (mbq_pkg::cfg_reg_t'(cfg_index))
        mbq_pkg::REG_NOMINAL:    nominal_bw <= cfg_data;
        mbq_pkg::REG_COEFF:      coeff      <= cfg_data;
        mbq_pkg::REG_BACKGROUND: background <= cfg_data[mbq_pkg::BG_W-1:0];
        default: ;
      endcase
    end
  end

  // item capture
  always_ff @(posedge clk) begin
    if (cmd.latch_item) begin
      item_op   <= s_tuser;
      item_id   <= s_tdata[mbq_pkg::ID_W-1:0];
      item_size <= s_tdata[mbq_pkg::IN_DATA_W-1:mbq_pkg::ID_W];
    end
  end

  // queue addressing with wrap
  always_comb begin
    tail_sum = {1'b0, head} + (mbq_pkg::PTR_W+1)'(count);
    if (tail_sum >= (mbq_pkg::PTR_W+1)'(mbq_pkg::QUEUE_DEPTH)) begin
      tail = mbq_pkg::PTR_W'(tail_sum - (mbq_pkg::PTR_W+1)'(mbq_pkg::QUEUE_DEPTH));
    end else begin
      tail = mbq_pkg::PTR_W'(tail_sum);
    end
    head_next = (head == mbq_pkg::PTR_W'(mbq_pkg::QUEUE_DEPTH - 1)) ?
                '0 : head + mbq_pkg::PTR_W'(1);
    full = count == mbq_pkg::CNT_W'(mbq_pkg::QUEUE_DEPTH);
  end

  // queue memory, registered read at the head
  always_ff @(posedge clk) begin
    if (cmd.enqueue) begin
      queue_mem[tail] <= {item_size, item_id};
    end
    if (cmd.pop) begin
      rd_entry <= queue_mem[head];
    end
  end

  // bank control state
  always_ff @(posedge clk) begin
    if (rst) begin
      serving    <= 1'b0;
      remaining  <= '0;
      current_id <= '0;
      count      <= '0;
      head       <= '0;
      done_flag  <= 1'b0;
      done_id    <= '0;
      ovf_flag   <= 1'b0;
    end else begin
      if (cmd.latch_item) begin
        done_flag <= 1'b0;
        done_id   <= '0;
        ovf_flag  <= 1'b0;
      end
      if (cmd.start_new) begin
        current_id <= item_id;
      end
      if (cmd.load_fetch) begin
        current_id <= rd_entry[mbq_pkg::ID_W-1:0];
      end
      if (cmd.enqueue) begin
        count <= count + mbq_pkg::CNT_W'(1);
      end
      if (cmd.set_ovf) begin
        ovf_flag <= 1'b1;
      end
      if (cmd.dec_rem) begin
        remaining <= remaining - mbq_pkg::LAT_W'(1);
      end
      if (cmd.finish) begin
        remaining <= '0;
        serving   <= 1'b0;
        done_flag <= 1'b1;
        done_id   <= current_id;
      end
      if (cmd.pop) begin
        head  <= head_next;
        count <= count - mbq_pkg::CNT_W'(1);
      end
      // latency of at least one tick
      if (cmd.set_latency) begin
        serving   <= 1'b1;
        remaining <= (div_q == '0) ? mbq_pkg::LAT_W'(1) : div_q;
      end
    end
  end

  // size of the request entering service
  always_ff @(posedge clk) begin
    if (cmd.start_new) begin
      svc_size <= item_size;
    end else if (cmd.load_fetch) begin
      svc_size <= rd_entry[mbq_pkg::ENTRY_W-1:mbq_pkg::ID_W];
    end
  end

  // size times coefficient, registered
  always_ff @(posedge clk) begin
    if (cmd.mul_start) begin
      product <= mbq_pkg::DIV_N_W'(svc_size * coeff);
    end
  end

  // total intensity and corrected bandwidth
  always_comb begin
    total = mbq_pkg::DIV_D_W'(background) + mbq_pkg::DIV_D_W'(count)
          + mbq_pkg::DIV_D_W'(1);
    bw_fixed = (div_q[mbq_pkg::DIV_D_W-1:0] == '0) ?
               mbq_pkg::DIV_D_W'(1) : div_q[mbq_pkg::DIV_D_W-1:0];
  end

  // divider operand select: first pass bandwidth, second pass latency
  always_comb begin
    div_start = cmd.mul_start || cmd.div2_start;
    if (cmd.mul_start) begin
      div_dividend = mbq_pkg::DIV_N_W'(nominal_bw);
      div_divisor  = total;
    end else begin
      div_dividend = product;
      div_divisor  = bw_fixed;
    end
  end

  mbq_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .busy     (div_busy),
    .done     (div_done),
    .quotient (div_q)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.load_out) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      m_tdata <= {ovf_flag, mbq_pkg::QLEN_W'(count), serving, done_id, done_flag};
    end
  end

  // status toward the controller
  always_comb begin
    stat.op       = item_op;
    stat.serving  = serving;
    stat.rem_le1  = remaining <= mbq_pkg::LAT_W'(1);
    stat.nonempty = count != '0;
    stat.full     = full;
    stat.div_done = div_done;
    stat.out_busy = m_tvalid && !m_tready;
  end

`ifndef ASSERT_OFF
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= mbq_pkg::CNT_W'(mbq_pkg::QUEUE_DEPTH))
    else $error("queue count beyond depth");
  a_serving_time: assert property (@(posedge clk) disable iff (rst)
    serving |-> remaining != '0)
    else $error("serving with no remaining time");
  a_enqueue_room: assert property (@(posedge clk) disable iff (rst)
    cmd.enqueue |-> !full)
    else $error("enqueue into a full queue");
  a_div_quiet: assert property (@(posedge clk) disable iff (rst)
    cmd.set_latency |-> !div_busy)
    else $error("latency taken while divider busy");
`endif

endmodule

@@ hdl/memory_bank_queue_timing_model_core.sv @@
// top level of the memory bank queue timing model
// depends on mbq_pkg, mbq_ctrl, mbq_datapath (which holds mbq_div)
//
// usage:
//   s_* carries one item per request: s_tuser is the operation (0 = request
//   arrives, 1 = one nanosecond tick), s_tdata the request id and size.
//   m_* returns exactly one result per item. cfg_* writes nominal bandwidth
//   (0), correction coefficient (1) and background intensity (2); other
//   indexes are ignored. cfg_ready is always high; write only while idle.
// sequencing:
//   an item that starts no service goes from EXEC straight to RESULT. An item that
//   starts service (arrival at an idle bank, or a tick that finishes a request while
//   others wait) passes FETCH when it pulls a waiting request, then MUL and two
//   passes through the shared bit-serial divider, bandwidth and then latency.
//   One item is in work at a time; the next is taken while the previous
//   result waits in the output register.
// reset: rst clears bank state, queue count and pointer, and loads register
//   defaults (16, 100, 0). No clearing pass is needed.
// stall: while m_tready is low the result holds; the block finishes the next
//   item and then waits before loading its result.
module memory_bank_queue_timing_model_core (
  input  logic                           clk,
  input  logic                           rst,
  // request channel
  input  logic                           s_tvalid,
  output logic                           s_tready,
  input  logic [mbq_pkg::IN_DATA_W-1:0]  s_tdata,   // request_id[15:0], size_bytes[31:16]
  input  logic                           s_tuser,   // operation
  // result channel
  output logic                           m_tvalid,
  input  logic                           m_tready,
  output logic [mbq_pkg::OUT_DATA_W-1:0] m_tdata,   // done_res[0], done_id[16:1],
                                                    // busy_res[17], queue_length[22:18],
                                                    // overflow[23]
  // configuration channel
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [mbq_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [mbq_pkg::CFG_W-1:0]      cfg_data
);

  mbq_pkg::cmd_t    cmd;
  mbq_pkg::status_t stat;

  // register writes always taken
  assign cfg_ready = 1'b1;

  mbq_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  mbq_datapath u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .s_tuser   (s_tuser),
    .s_tdata   (s_tdata),
    .m_tready  (m_tready),
    .m_tvalid  (m_tvalid),
    .m_tdata   (m_tdata),
    .cmd       (cmd),
    .stat      (stat)
  );

endmodule

@@ sim/mbq_checker.sv @@
// result checker for the memory bank queue timing model: watches all three channels,
// keeps its own copy of the bank state and register values, and compares every result
// depends on mbq_pkg only; instantiated beside the block by tb
module mbq_checker (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_tvalid,
  input  logic                           s_tready,
  input  logic [mbq_pkg::IN_DATA_W-1:0]  s_tdata,   // request_id[15:0], size_bytes[31:16]
  input  logic                           s_tuser,   // operation
  input  logic                           m_tvalid,
  input  logic                           m_tready,
  input  logic [mbq_pkg::OUT_DATA_W-1:0] m_tdata,   // done_res[0], done_id[16:1],
                                                    // busy_res[17], queue_length[22:18],
                                                    // overflow[23]
  input  logic                           cfg_valid,
  input  logic                           cfg_ready,
  input  logic [mbq_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [mbq_pkg::CFG_W-1:0]      cfg_data,
  output int                             errors,
  output int                             outstanding,
  output int                             requests_seen,
  output int                             done_seen,
  output int                             overflow_seen,
  output logic                           bank_busy
);
  timeunit 1ns;
  timeprecision 1ps;
  import mbq_pkg::*;

  // one result, laid out as on m_tdata
  typedef struct packed {
    logic              overflow;
    logic [QLEN_W-1:0] queue_length;
    logic              busy;
    logic [ID_W-1:0]   done_id;
    logic              done;
  } bank_result_t;

  // register copies
  logic [CFG_W-1:0] nominal_bw;
  logic [CFG_W-1:0] coeff;
  logic [BG_W-1:0]  background;

  // bank state copy; waiting entries are {size, id}
  logic                 serving;
  logic [LAT_W-1:0]     remaining;
  logic [ID_W-1:0]      current_id;
  logic [ENTRY_W-1:0]   wait_list[$];

  bank_result_t expected_results[$];
  int err_total, requests_total, done_total, ovf_total;

  initial begin
    errors = 0;
    outstanding = 0;
    requests_seen = 0;
    done_seen = 0;
    overflow_seen = 0;
    bank_busy = 1'b0;
    err_total = 0;
    requests_total = 0;
    done_total = 0;
    ovf_total = 0;
  end

  // service ticks for a request of this size, using the queue length after any pop
  function automatic logic [LAT_W-1:0] service_ticks(logic [SIZE_W-1:0] size);
    logic [63:0] load, bw, ticks;
    load = 64'(background) + 64'(wait_list.size()) + 64'd1;
    bw = 64'(nominal_bw) / load;
    // a corrected bandwidth of zero counts as one
    if (bw == 64'd0) bw = 64'd1;
    ticks = (64'(size) * 64'(coeff)) / bw;
    if (ticks > 64'hFFFF_FFFF) ticks = 64'hFFFF_FFFF;
    if (ticks == 64'd0) ticks = 64'd1;
    return ticks[LAT_W-1:0];
  endfunction

  function automatic void begin_service(logic [ID_W-1:0] id, logic [SIZE_W-1:0] size);
    serving = 1'b1;
    current_id = id;
    remaining = service_ticks(size);
  endfunction

  // advance the bank by one request or tick and return the expected result
  function automatic bank_result_t bank_step(logic op, logic [ID_W-1:0] id,
                                             logic [SIZE_W-1:0] size);
    bank_result_t res;
    logic [ENTRY_W-1:0] head;
    res = '0;
    if (op == OP_ARRIVE) begin
      if (!serving) begin
        begin_service(id, size);
      end else if (wait_list.size() < QUEUE_DEPTH) begin
        wait_list.push_back({size, id});
      end else begin
        // queue full: request dropped, state untouched
        res.overflow = 1'b1;
      end
    end else if (serving) begin
      if (remaining <= 1) begin
        remaining = '0;
        res.done = 1'b1;
        res.done_id = current_id;
        serving = 1'b0;
        if (wait_list.size() != 0) begin
          head = wait_list.pop_front();
          begin_service(head[ID_W-1:0], head[ENTRY_W-1:ID_W]);
        end
      end else begin
        remaining = remaining - 1;
      end
    end
    res.busy = serving;
    res.queue_length = QLEN_W'(wait_list.size());
    return res;
  endfunction

  function automatic void check_field(string name, longint unsigned want,
                                      longint unsigned got);
    if (want != got) begin
      $display("%0t ns checker: %s expected 0x%0h, got 0x%0h", $time, name, want, got);
      err_total++;
    end
  endfunction

  // observe register writes, requests and results at each edge
  always @(posedge clk) begin
    bank_result_t want, got;
    if (rst) begin
      nominal_bw = NOMINAL_RST;
      coeff = COEFF_RST;
      background = BG_RST;
      serving = 1'b0;
      remaining = '0;
      current_id = '0;
      wait_list.delete();
      expected_results.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_NOMINAL:    nominal_bw = cfg_data;
          REG_COEFF:      coeff = cfg_data;
          REG_BACKGROUND: background = cfg_data[BG_W-1:0];
          default: ;
        endcase
      end
      if (m_tvalid && m_tready) begin
        got = bank_result_t'(m_tdata);
        if (expected_results.size() == 0) begin
          $display("%0t ns checker: expected no result, got 0x%0h", $time, m_tdata);
          err_total++;
        end else begin
          want = expected_results.pop_front();
          check_field("done_res", want.done, got.done);
          check_field("done_id", want.done_id, got.done_id);
          check_field("busy_res", want.busy, got.busy);
          check_field("queue_length", want.queue_length, got.queue_length);
          check_field("overflow", want.overflow, got.overflow);
        end
      end
      if (s_tvalid && s_tready) begin
        want = bank_step(s_tuser, s_tdata[ID_W-1:0], s_tdata[IN_DATA_W-1:ID_W]);
        expected_results.push_back(want);
        requests_total++;
        if (want.done) done_total++;
        if (want.overflow) ovf_total++;
      end
    end
    errors <= err_total;
    outstanding <= expected_results.size();
    requests_seen <= requests_total;
    done_seen <= done_total;
    overflow_seen <= ovf_total;
    bank_busy <= serving || (wait_list.size() != 0);
  end

endmodule

@@ sim/tb.sv @@
// testbench top for memory_bank_queue_timing_model_core: clock, reset, request and
// register stimulus, receiver stalls, watchdog and verdict
// depends on mbq_pkg, the block's RTL and mbq_checker
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import mbq_pkg::*;

  localparam int STALL_LIMIT = 4000;
  localparam int HOLD_CYCLES = 300;
  // index with no register behind it
  localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [IN_DATA_W-1:0]  s_tdata = '0;   // request_id[15:0], size_bytes[31:16]
  logic                  s_tuser = 1'b0; // operation
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_tdata;        // done_res[0], done_id[16:1], busy_res[17],
                                         // queue_length[22:18], overflow[23]
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_W-1:0]      cfg_data = '0;

  int   errors, outstanding, requests_seen, done_seen, overflow_seen;
  logic bank_busy;

  int   send_idle_pct = 0;
  int   stall_pct = 0;
  logic hold_req = 1'b0;
  logic hold_taken = 1'b0;
  int   hold_left = 0;
  int   quiet = 0;

  memory_bank_queue_timing_model_core dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  mbq_checker u_checker (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .errors(errors), .outstanding(outstanding), .requests_seen(requests_seen),
    .done_seen(done_seen), .overflow_seen(overflow_seen), .bank_busy(bank_busy)
  );

  // 10 ns clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // receiver: random stalls, plus one long hold-off while requests keep coming
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else if (hold_left != 0) begin
      m_tready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (hold_req && !hold_taken) begin
      m_tready <= 1'b0;
      hold_taken <= 1'b1;
      hold_left <= HOLD_CYCLES;
    end else begin
      m_tready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // watchdog on cycles with no transfer on any channel
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
      quiet <= 0;
    else
      quiet <= quiet + 1;
    if (quiet >= STALL_LIMIT) begin
      $display("tb: no transfer for %0d cycles at %0t ns", quiet, $time);
      $display("tb: done, errors");
      $finish;
    end
  end

  // offer one request or tick, with random idle cycles ahead of it
  task automatic send_item(logic op, logic [ID_W-1:0] id, logic [SIZE_W-1:0] size);
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser <= op;
    s_tdata <= {size, id};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
  endtask

  // stop offering and wait for every outstanding result
  task automatic wait_all_results();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // tick until the bank has finished everything it holds
  task automatic drain_bank();
    wait_all_results();
    while (bank_busy) begin
      repeat (8) send_item(OP_TICK, ID_W'($urandom), SIZE_W'($urandom));
      wait_all_results();
    end
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // new register setting and idle mix; called only with the block idle
  task automatic set_phase(int nominal, int coeff, int background, int idle, int stall);
    write_reg(REG_NOMINAL, CFG_W'(nominal));
    write_reg(REG_COEFF, CFG_W'(coeff));
    write_reg(REG_BACKGROUND, CFG_W'(background));
    send_idle_pct = idle;
    stall_pct <= stall;
  endtask

  // mostly ticks so services complete, arrivals with random ids
  task automatic random_items(int count, int size_max);
    repeat (count) begin
      if ($urandom_range(99) < 70)
        send_item(OP_TICK, ID_W'($urandom), SIZE_W'($urandom));
      else
        send_item(OP_ARRIVE, ID_W'($urandom), SIZE_W'($urandom_range(size_max)));
    end
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed, reset register values: idle tick, shortest service, full queue
    send_item(OP_TICK, 16'hFFFF, 16'hFFFF);
    send_item(OP_ARRIVE, 16'h0000, 16'h0000);
    send_item(OP_TICK, 16'h0000, 16'h0000);
    send_item(OP_ARRIVE, 16'hFFFF, 16'h0001);
    for (int i = 0; i < QUEUE_DEPTH + 1; i++)
      send_item(OP_ARRIVE, ID_W'(i * 16'h0F0F), 16'h0000);
    drain_bank();

    // wide bandwidth, full-range sizes, no idling; long receiver hold-off
    set_phase(65535, 1, 0, 0, 0);
    hold_req <= 1'b1;
    random_items(60, 65535);
    drain_bank();

    // zero nominal bandwidth, heavy background, sender mostly idle
    set_phase(0, 1, 255, 76, 0);
    random_items(50, 7);
    drain_bank();

    // zero coefficient, receiver mostly stalled; spare index must be ignored
    set_phase(65535, 0, 255, 0, 76);
    write_reg(REG_SPARE, 16'hFFFF);
    random_items(80, 65535);
    drain_bank();

    // mid-range setting, light idling on both sides
    set_phase(1000, 3, 7, 14, 14);
    random_items(50, 127);
    drain_bank();

    // extreme setting: longest latency, then fill the queue past its depth
    set_phase(1, 65535, 255, 14, 14);
    send_item(OP_ARRIVE, 16'hFFFF, 16'hFFFF);
    repeat (QUEUE_DEPTH + 1) send_item(OP_ARRIVE, ID_W'($urandom), 16'hFFFF);
    repeat (10) send_item(OP_TICK, ID_W'($urandom), SIZE_W'($urandom));
    wait_all_results();
    repeat (20) @(posedge clk);

    $display("tb: %0d requests checked, %0d completions, %0d overflows", requests_seen,
             done_seen, overflow_seen);
    $display("tb: six register settings incl. extremes, idle/stall mixes, one long hold");
    if (errors == 0 && outstanding == 0)
      $display("tb: done, clean");
    else
      $display("tb: done, errors");
    $finish;
  end

endmodule
